/* design/frfifo_pkg.sv */
// package: sizes, codes and word types of the frame ring fifo
`timescale 1ns / 1ps

package frfifo_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_SIZE  = 256;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int PTR_W  = SLOT_W + 1;
  localparam int OFF_W  = $clog2(SLOT_SIZE);
  localparam int LEN_W  = $clog2(SLOT_SIZE + 1);
  localparam int ADDR_W = SLOT_W + OFF_W;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_READ = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PS_OK       = 2'd0,
    PS_TOO_LONG = 2'd1,
    PS_FULL     = 2'd2,
    PS_NONE     = 2'd3
  } push_status_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] frame_len;
    logic        first_beat;
    logic        last_beat;
    logic [7:0]  byte_offset;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    push_status_t push_status;
    logic         ring_empty;
    logic [8:0]   front_length;
    logic [7:0]   read_data;
    logic [4:0]   frame_count;
    logic [31:0]  drop_total;
  } out_word_t;

  typedef struct packed {
    logic take;
  } ctrl_cmd_t;

endpackage

/* design/frfifo_if.sv */
// interfaces: request and response channels with valid/ready handshake
`timescale 1ns / 1ps

interface frfifo_in_if import frfifo_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frfifo_out_if import frfifo_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/frfifo_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module frfifo_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/frfifo_ctrl.sv */
// controller: accept one word, then hold the response until taken
`timescale 1ns / 1ps

module frfifo_ctrl import frfifo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_RESP:  out_valid = 1'b1;
      default: in_ready = 1'b0;
    endcase
    cmd.take = in_valid && in_ready;
  end

endmodule

/* design/frfifo_dp.sv */
// datapath: ring pointers, slot lengths, byte store and drop counter
`timescale 1ns / 1ps

module frfifo_dp import frfifo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  in_word_t  word,
  output out_word_t result
);

  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [31:0]       drops;
  logic              fip;
  logic [LEN_W-1:0]  latched;
  logic [LEN_W-1:0]  lengths [SLOT_COUNT];
  push_status_t      status;
  logic              rd_hit;

  logic [PTR_W-1:0]  count;
  logic              empty;
  logic              full;
  logic [LEN_W-1:0]  front_len;
  logic [LEN_W-1:0]  offs_ext;
  logic              is_push;
  logic              too_long;
  logic              start_ok;
  logic              fip_eff;
  logic [LEN_W-1:0]  len_eff;
  logic              wr_en;
  logic              rd_en;
  logic [7:0]        mem_q;
  push_status_t      status_next;

  assign count     = wp - rp;
  assign empty     = (count == '0);
  assign full      = (count == PTR_W'(SLOT_COUNT));
  assign front_len = lengths[rp[SLOT_W-1:0]];
  assign offs_ext  = LEN_W'(word.byte_offset);
  assign is_push   = (word.operation == OP_PUSH);
  assign too_long  = (word.frame_len > 16'(SLOT_SIZE));
  assign start_ok  = word.first_beat && !too_long && !full;
  assign fip_eff   = word.first_beat ? start_ok : fip;
  assign len_eff   = start_ok ? word.frame_len[LEN_W-1:0] : latched;
  assign wr_en     = cmd.take && is_push && fip_eff && (offs_ext < len_eff);
  assign rd_en     = cmd.take && (word.operation == OP_READ);

  always_comb begin
    if (!is_push) begin
      status_next = PS_NONE;
    end else if (word.first_beat && too_long) begin
      status_next = PS_TOO_LONG;
    end else if (word.first_beat && full) begin
      status_next = PS_FULL;
    end else if (fip_eff) begin
      status_next = PS_OK;
    end else begin
      status_next = PS_NONE;
    end
  end

  frfifo_ram #(
    .DATA_W (8),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({wp[SLOT_W-1:0], word.byte_offset[OFF_W-1:0]}),
    .wr_data (word.data_byte),
    .rd_en   (rd_en),
    .rd_addr ({rp[SLOT_W-1:0], word.byte_offset[OFF_W-1:0]}),
    .rd_data (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      drops   <= '0;
      fip     <= 1'b0;
      latched <= '0;
    end else if (cmd.take) begin
      case (word.operation)
        OP_PUSH: begin
          if (word.first_beat && !start_ok) begin
            drops <= drops + 32'd1;
          end
          if (start_ok) begin
            latched <= len_eff;
          end
          if (fip_eff && word.last_beat) begin
            wp  <= wp + PTR_W'(1);
            fip <= 1'b0;
          end else begin
            fip <= fip_eff;
          end
        end
        OP_POP: begin
          if (!empty) begin
            rp <= rp + PTR_W'(1);
          end
        end
        default: begin
          fip <= fip;
        end
      endcase
    end
  end

  // slot lengths and response fields carry no reset
  always_ff @(posedge clk) begin
    if (cmd.take && is_push && fip_eff && word.last_beat) begin
      lengths[wp[SLOT_W-1:0]] <= len_eff;
    end
    if (cmd.take) begin
      status <= status_next;
      rd_hit <= rd_en && !empty && (offs_ext < front_len);
    end
  end

  always_comb begin
    result.push_status  = status;
    result.ring_empty   = empty;
    result.front_length = empty ? '0 : front_len;
    result.read_data    = rd_hit ? mem_q : 8'd0;
    result.frame_count  = count;
    result.drop_total   = drops;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PTR_W'(SLOT_COUNT))
    else $error("frame count above slot count");

  a_drops_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.take |=> $stable(drops))
    else $error("drop counter moved without a word");

  a_rp_pop_only: assert property (@(posedge clk) disable iff (rst)
    cmd.take && word.operation != OP_POP |=> $stable(rp))
    else $error("tail moved on a word that is not a pop");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    cmd.take && is_push && word.first_beat && full |=> drops == $past(drops) + 32'd1)
    else $error("first beat on a full ring not counted as a drop");

endmodule

/* design/frame_ring_fifo_with_drop_count_core.sv */
// top level: frame ring fifo with drop counter
//
//   channel  dir  payload     meaning
//   req      in   in_word_t   push beat, front byte read, pop, or no-op
//   rsp      out  out_word_t  push status, ring state, read byte, drop total
//
// every word is accepted in S_IDLE, then answered from S_RESP
// the response waits in its register while rsp.ready is low; req.ready stays low
// the byte store has one registered read port, which sets the response cycle
// reset (rst, synchronous) empties the ring and clears the drop counter
// no clearing pass: slot bytes and lengths are undefined until written
`timescale 1ns / 1ps

module frame_ring_fifo_with_drop_count_core import frfifo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  frfifo_in_if.sink    req,
  frfifo_out_if.source rsp
);

  ctrl_cmd_t cmd;

  frfifo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  frfifo_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .word   (req.data),
    .result (rsp.data)
  );

endmodule

/* tb/sv/testbench.sv */
// testbench: frame ring fifo driven with directed corner cases and random frames, checked word by word by a scoreboard
`timescale 1ns / 1ps

module testbench;
  import frfifo_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;

  class frame_ring_scoreboard;
    logic [7:0]       store_bytes [SLOT_COUNT*SLOT_SIZE];
    bit               store_known [SLOT_COUNT*SLOT_SIZE];
    logic [8:0]       slot_len [SLOT_COUNT];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [31:0]      drops;
    bit               in_frame;
    logic [8:0]       cur_len;
    out_word_t        results_due [$];
    int               mismatches;
    int unsigned      handled;

    function new();
      foreach (store_known[i]) store_known[i] = 1'b0;
      wr_ptr = '0;
      rd_ptr = '0;
      drops = '0;
      in_frame = 1'b0;
      cur_len = '0;
      mismatches = 0;
      handled = 0;
    endfunction

    function int unsigned fill();
      logic [PTR_W-1:0] d;
      d = wr_ptr - rd_ptr;
      return d;
    endfunction

    function int unsigned front_len();
      return (fill() == 0) ? 0 : slot_len[rd_ptr[SLOT_W-1:0]];
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // never read a byte of the front slot that was not written since reset
    function bit read_safe(logic [7:0] offs);
      logic [SLOT_W-1:0] sl;
      sl = rd_ptr[SLOT_W-1:0];
      if (fill() == 0 || offs >= slot_len[sl]) return 1'b1;
      return store_known[{sl, offs}];
    endfunction

    function void note_input(in_word_t w);
      push_status_t     st;
      logic [7:0]       rdat;
      logic [SLOT_W-1:0] sl;
      out_word_t        e;
      st = PS_NONE;
      rdat = '0;
      case (w.operation)
        OP_PUSH: begin
          if (w.first_beat) begin
            in_frame = 1'b0;
            if (w.frame_len > SLOT_SIZE) begin
              drops = drops + 1;
              st = PS_TOO_LONG;
            end else if (fill() >= SLOT_COUNT) begin
              drops = drops + 1;
              st = PS_FULL;
            end else begin
              in_frame = 1'b1;
              cur_len = w.frame_len[8:0];
            end
          end
          if (in_frame) begin
            sl = wr_ptr[SLOT_W-1:0];
            st = PS_OK;
            if (w.byte_offset < cur_len) begin
              store_bytes[{sl, w.byte_offset}] = w.data_byte;
              store_known[{sl, w.byte_offset}] = 1'b1;
            end
            if (w.last_beat) begin
              slot_len[sl] = cur_len;
              wr_ptr = wr_ptr + 1'b1;
              in_frame = 1'b0;
            end
          end
        end
        OP_READ: begin
          if (fill() != 0) begin
            sl = rd_ptr[SLOT_W-1:0];
            if (w.byte_offset < slot_len[sl]) rdat = store_bytes[{sl, w.byte_offset}];
          end
        end
        OP_POP: begin
          if (fill() != 0) rd_ptr = rd_ptr + 1'b1;
        end
        default: ;
      endcase
      handled++;
      e.push_status = st;
      e.ring_empty = (fill() == 0);
      e.front_length = 9'(front_len());
      e.read_data = rdat;
      e.frame_count = 5'(fill());
      e.drop_total = drops;
      results_due.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (results_due.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = results_due.pop_front();
      if (got.push_status !== want.push_status)
        report($sformatf("push_status got %0d want %0d", got.push_status, want.push_status));
      if (got.ring_empty !== want.ring_empty)
        report($sformatf("ring_empty got %0d want %0d", got.ring_empty, want.ring_empty));
      if (got.front_length !== want.front_length)
        report($sformatf("front_length got %0d want %0d", got.front_length, want.front_length));
      if (got.read_data !== want.read_data)
        report($sformatf("read_data got %0h want %0h", got.read_data, want.read_data));
      if (got.frame_count !== want.frame_count)
        report($sformatf("frame_count got %0d want %0d", got.frame_count, want.frame_count));
      if (got.drop_total !== want.drop_total)
        report($sformatf("drop_total got %0d want %0d", got.drop_total, want.drop_total));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   gaps_on = 1'b1;
  bit   hold_request = 1'b0;
  int   quiet = 0;

  frame_ring_scoreboard ring_sb;

  frfifo_in_if  req_ch ();
  frfifo_out_if rsp_ch ();

  frame_ring_fifo_with_drop_count_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic in_word_t rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t make_word(op_t op, logic [15:0] len, logic first, logic last,
                                         logic [7:0] offs, logic [7:0] dat);
    in_word_t w;
    w.operation = op;
    w.frame_len = len;
    w.first_beat = first;
    w.last_beat = last;
    w.byte_offset = offs;
    w.data_byte = dat;
    return w;
  endfunction

  function automatic int pick_len(bit tiny);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom_range(SLOT_SIZE + 1, 65535);
    if (tiny) return $urandom_range(0, 3);
    if (r < 6) return SLOT_SIZE;
    if (r < 10) return $urandom_range(13, SLOT_SIZE);
    return $urandom_range(0, 12);
  endfunction

  task automatic send_word(input in_word_t w);
    req_ch.data = w;
    req_ch.valid = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ring_sb.note_input(w);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
  endtask

  task automatic push_frame(input int len, input bit finish, input bit shuffled);
    in_word_t w;
    int       beats;
    int       i;
    beats = (len > SLOT_SIZE) ? $urandom_range(1, 4) : ((len == 0) ? 1 : len);
    if (!finish && beats > 1) beats = $urandom_range(1, beats - 1);
    for (i = 0; i < beats; i++) begin
      w = rand_word();
      w.operation = OP_PUSH;
      w.first_beat = (i == 0);
      w.last_beat = finish && (i == beats - 1);
      if (i == 0) w.frame_len = 16'(len);
      if (!shuffled) w.byte_offset = 8'(i);
      send_word(w);
    end
  endtask

  task automatic read_front();
    in_word_t    w;
    int unsigned start;
    int          k;
    bit          found;
    w = rand_word();
    w.operation = OP_READ;
    start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, ring_sb.front_len());
    found = 1'b0;
    for (k = 0; k < 256 && !found; k++) begin
      w.byte_offset = 8'(start + k);
      found = ring_sb.read_safe(w.byte_offset);
    end
    if (!found) w.operation = OP_NOP;
    send_word(w);
  endtask

  task automatic pop_front();
    in_word_t w;
    w = rand_word();
    w.operation = OP_POP;
    send_word(w);
  endtask

  task automatic random_action(input int push_pct, input int pop_pct, input bit tiny);
    int unsigned r;
    in_word_t    w;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      push_frame(pick_len(tiny), $urandom_range(0, 11) != 0, $urandom_range(0, 7) == 0);
    end else if (r < push_pct + pop_pct) begin
      pop_front();
    end else if (r < 94) begin
      read_front();
    end else begin
      w = rand_word();
      if (w.operation == OP_READ) read_front();
      else send_word(w);
    end
  endtask

  task automatic drain_wait();
    while (ring_sb.pending() != 0) @(negedge clk);
  endtask

  // receiver: random stalls plus one long hold on request
  initial begin
    int unsigned stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready = 1'b0;
        stall = pick_gap() - 1;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) ring_sb.check_result(rsp_ch.data);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int  mode;
    bit  held;
    bit  first_phase;
    ring_sb = new();
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    held = 1'b0;
    first_phase = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corner cases
    send_word(make_word(OP_POP, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 8'hFF));
    send_word(make_word(OP_READ, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_NOP, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_PUSH, 16'd0, 1'b1, 1'b1, 8'h00, 8'hFF));
    send_word(make_word(OP_READ, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_POP, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_PUSH, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_PUSH, 16'h0000, 1'b0, 1'b1, 8'h01, 8'h55));
    send_word(make_word(OP_PUSH, 16'd257, 1'b1, 1'b1, 8'h00, 8'h00));
    send_word(make_word(OP_PUSH, 16'd256, 1'b1, 1'b1, 8'hFF, 8'hA5));
    send_word(make_word(OP_READ, 16'h0000, 1'b0, 1'b0, 8'hFF, 8'h00));
    send_word(make_word(OP_POP, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_PUSH, 16'd3, 1'b1, 1'b0, 8'h00, 8'h11));
    send_word(make_word(OP_PUSH, 16'd2, 1'b1, 1'b0, 8'h00, 8'h22));
    send_word(make_word(OP_PUSH, 16'h0000, 1'b0, 1'b1, 8'h01, 8'h33));
    send_word(make_word(OP_READ, 16'h0000, 1'b0, 1'b0, 8'h01, 8'h00));
    send_word(make_word(OP_PUSH, 16'd1, 1'b1, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_PUSH, 16'h0000, 1'b0, 1'b1, 8'hC8, 8'hEE));
    send_word(make_word(OP_READ, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_POP, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_READ, 16'h0000, 1'b0, 1'b0, 8'hC8, 8'h00));
    send_word(make_word(OP_READ, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    send_word(make_word(OP_POP, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
    drain_wait();

    // random phases: balanced, filling, draining
    while (ring_sb.handled < ITEM_TARGET) begin
      mode = first_phase ? 1 : $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (first_phase ? 40 : $urandom_range(15, 40)) begin
        if (ring_sb.handled >= ITEM_TARGET) break;
        case (mode)
          0: random_action(40, 25, 1'b0);
          1: random_action(75, 5, 1'b1);
          default: random_action(10, 55, 1'b0);
        endcase
        if (!held && ring_sb.handled > 400) begin
          hold_request = 1'b1;
          held = 1'b1;
        end
      end
      first_phase = 1'b0;
      if ($urandom_range(0, 4) == 0) drain_wait();
    end

    req_ch.valid = 1'b0;
    while (ring_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ring_sb.pending() != 0) ring_sb.report("expected results left over");
    if (ring_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
